>>> hdl/text_console_cursor_engine_assert.svh
// assertion macros used by the console engine checker
// depends on nothing; included by the checker file
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after its trigger
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcce_pkg.sv
// shared types and codes of the text console cursor engine
// no dependencies; imported by every engine module but tcce_fifo
`default_nettype none

package tcce_pkg;

    // input word
    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        char_code;
        logic signed [7:0] position_row;
        logic signed [7:0] position_col;
        logic [7:0]        cell_attr;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       scrolled;
    } out_word_t;

    // action codes of the input word
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_DRAW  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // classified commands handed from front to back
    localparam logic [2:0] OP_CHAR      = 3'd0;
    localparam logic [2:0] OP_NEWLINE   = 3'd1;
    localparam logic [2:0] OP_BACKSPACE = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_DRAW      = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;
    localparam logic [2:0] OP_NOP       = 3'd6;

    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_RESET    = 8'h0F;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] attr;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/tcce_fifo.sv
// two-entry word queue, used between front and back and on the result side
// standalone; word type set by parameter
`default_nettype none

module tcce_fifo #(
    parameter type word_t = logic [7:0]
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  word_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output word_t rd_data,
    output logic  empty
);

    word_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tcce_front.sv
// front end: takes input words and classifies them into back-end commands
// depends on tcce_pkg
`default_nettype none

module tcce_front import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  in_word_t in_data,
    input  logic     push,
    output logic     full,
    input  logic     q_full,
    input  logic     busy,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic row_ok;
    logic col_ok;
    logic on_screen;

    assign full   = q_full || busy;
    assign q_push = push && !full;

    // off-screen when negative or past the last row or column
    assign row_ok    = !in_data.position_row[7] && (in_data.position_row[6:0] < 7'(ROWS));
    assign col_ok    = !in_data.position_col[7] && (in_data.position_col[6:0] < 7'(COLUMNS));
    assign on_screen = row_ok && col_ok;

    always_comb
    begin
        q_cmd.ch   = in_data.char_code;
        q_cmd.row  = in_data.position_row[6:0];
        q_cmd.col  = in_data.position_col[6:0];
        q_cmd.attr = in_data.cell_attr;
        case (in_data.action)
            ACT_PUT:
            begin
                if (in_data.char_code == CHR_NEWLINE)
                begin
                    q_cmd.op = OP_NEWLINE;
                end
                else if (in_data.char_code == CHR_BACKSPACE)
                begin
                    q_cmd.op = OP_BACKSPACE;
                end
                else
                begin
                    q_cmd.op = OP_CHAR;
                end
            end
            ACT_CLEAR: q_cmd.op = OP_CLEAR;
            ACT_DRAW:  q_cmd.op = on_screen ? OP_DRAW : OP_NOP;
            ACT_READ:  q_cmd.op = on_screen ? OP_READ : OP_NOP;
            default:   q_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/tcce_back.sv
// back end: screen memory, cursor, scroll and clear sequencer, attribute register
// depends on tcce_pkg
`default_nettype none

module tcce_back import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic [7:0] cfg_data,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_word_t res_word,
    output logic      init_busy
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int RW1   = RW + 1;
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_LIMIT = RW'(ROWS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] COL_LIMIT = CW'(COLUMNS);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [7:0]    attr_reg;
    logic [RW-1:0] cur_row_reg;
    logic [RW-1:0] cur_row_next;
    logic [CW-1:0] cur_col_reg;
    logic [CW-1:0] cur_col_next;
    logic [RW-1:0] top_reg;
    logic [RW-1:0] top_next;
    logic [AW-1:0] top_base_reg;
    logic [AW-1:0] top_base_next;
    logic [AW-1:0] fill_addr_reg;
    logic [AW-1:0] fill_addr_next;
    logic [AW-1:0] fill_end_reg;
    logic [AW-1:0] fill_end_next;
    logic [15:0]   fill_cell_reg;
    logic [15:0]   fill_cell_next;
    logic          scroll_flag_reg;
    logic          scroll_flag_next;

    logic [15:0]   screen_mem [DEPTH];
    logic [15:0]   rdata_reg;

    logic          mem_we;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [RW1-1:0] row_sum;
    logic [RW-1:0] phys_row;
    logic [AW-1:0] cell_addr;

    logic [RW-1:0] bs_row;
    logic [CW-1:0] bs_col;
    logic [RW-1:0] step_row;
    logic [CW-1:0] step_col;
    logic [RW-1:0] wrap_row;
    logic [CW-1:0] wrap_col;

    logic          res_scrolled;
    logic [15:0]   res_cell;
    logic [7:0]    row_wide;
    logic [7:0]    col_wide;

    assign init_busy = (state_reg == ST_INIT);

    // logical row to physical row through the circular top pointer
    assign row_sum   = {1'b0, sel_row} + {1'b0, top_reg};
    assign phys_row  = (row_sum >= RW1'(ROWS)) ? RW'(row_sum - RW1'(ROWS)) : RW'(row_sum);
    assign cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
    assign mem_waddr = (state_reg == ST_IDLE) ? cell_addr : fill_addr_reg;

    // backspace target, wraps to the end of the previous row
    always_comb
    begin
        bs_row = cur_row_reg;
        bs_col = cur_col_reg;
        if (cur_col_reg != '0)
        begin
            bs_col = cur_col_reg - 1'b1;
        end
        else if (cur_row_reg != '0)
        begin
            bs_row = cur_row_reg - 1'b1;
            bs_col = COL_LAST;
        end
    end

    // cursor step for a put, then column wrap
    always_comb
    begin
        step_row = cur_row_reg;
        step_col = cur_col_reg;
        case (cmd.op)
            OP_CHAR:
            begin
                step_col = cur_col_reg + 1'b1;
            end
            OP_NEWLINE:
            begin
                step_col = '0;
                step_row = cur_row_reg + 1'b1;
            end
            OP_BACKSPACE:
            begin
                step_row = bs_row;
                step_col = bs_col;
            end
            default:
            begin
                step_row = cur_row_reg;
                step_col = cur_col_reg;
            end
        endcase
        wrap_row = step_row;
        wrap_col = step_col;
        if (step_col >= COL_LIMIT)
        begin
            wrap_col = '0;
            wrap_row = step_row + 1'b1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        top_next         = top_reg;
        top_base_next    = top_base_reg;
        fill_addr_next   = fill_addr_reg;
        fill_end_next    = fill_end_reg;
        fill_cell_next   = fill_cell_reg;
        scroll_flag_next = scroll_flag_reg;
        mem_we           = 1'b0;
        mem_wdata        = {attr_reg, CHR_SPACE};
        sel_row          = cur_row_reg;
        sel_col          = cur_col_reg;
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        res_scrolled     = 1'b0;
        res_cell         = 16'd0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = fill_cell_reg;
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = fill_cell_reg;
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next   = ST_IDLE;
                    res_push     = 1'b1;
                    res_scrolled = scroll_flag_reg;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                res_push   = 1'b1;
                res_cell   = rdata_reg;
            end
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_CHAR, OP_NEWLINE, OP_BACKSPACE:
                        begin
                            if (cmd.op == OP_CHAR)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {attr_reg, cmd.ch};
                            end
                            else if (cmd.op == OP_BACKSPACE)
                            begin
                                mem_we  = 1'b1;
                                sel_row = bs_row;
                                sel_col = bs_col;
                            end
                            if (wrap_row >= ROW_LIMIT)
                            begin
                                // old top row becomes the blank bottom row
                                cur_row_next     = ROW_LAST;
                                cur_col_next     = wrap_col;
                                fill_addr_next   = top_base_reg;
                                fill_end_next    = top_base_reg + ROW_SPAN;
                                fill_cell_next   = {attr_reg, CHR_SPACE};
                                scroll_flag_next = 1'b1;
                                state_next       = ST_FILL;
                                if (top_reg == ROW_LAST)
                                begin
                                    top_next      = '0;
                                    top_base_next = '0;
                                end
                                else
                                begin
                                    top_next      = top_reg + 1'b1;
                                    top_base_next = top_base_reg + AW'(COLUMNS);
                                end
                            end
                            else
                            begin
                                cur_row_next = wrap_row;
                                cur_col_next = wrap_col;
                                res_push     = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cur_row_next     = '0;
                            cur_col_next     = '0;
                            top_next         = '0;
                            top_base_next    = '0;
                            fill_addr_next   = '0;
                            fill_end_next    = LAST_ADDR;
                            fill_cell_next   = {attr_reg, CHR_SPACE};
                            scroll_flag_next = 1'b0;
                            state_next       = ST_FILL;
                        end
                        OP_DRAW:
                        begin
                            mem_we    = 1'b1;
                            sel_row   = RW'(cmd.row);
                            sel_col   = CW'(cmd.col);
                            mem_wdata = {cmd.attr, cmd.ch};
                            res_push  = 1'b1;
                        end
                        OP_READ:
                        begin
                            sel_row    = RW'(cmd.row);
                            sel_col    = CW'(cmd.col);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign row_wide = 8'(cur_row_next);
    assign col_wide = 8'(cur_col_next);

    always_comb
    begin
        res_word.cursor_row_out = row_wide[4:0];
        res_word.cursor_col_out = col_wide[6:0];
        res_word.read_char      = res_cell[7:0];
        res_word.read_attr      = res_cell[15:8];
        res_word.scrolled       = res_scrolled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            attr_reg        <= ATTR_RESET;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            top_reg         <= '0;
            top_base_reg    <= '0;
            fill_addr_reg   <= '0;
            fill_end_reg    <= LAST_ADDR;
            fill_cell_reg   <= {ATTR_RESET, CHR_SPACE};
            scroll_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            top_reg         <= top_next;
            top_base_reg    <= top_base_next;
            fill_addr_reg   <= fill_addr_next;
            fill_end_reg    <= fill_end_next;
            fill_cell_reg   <= fill_cell_next;
            scroll_flag_reg <= scroll_flag_next;
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[cell_addr];
    end

endmodule

`default_nettype wire

>>> hdl/text_console_cursor_engine.sv
// text console cursor engine, top level: front end, command queue, back end, result queue
// depends on tcce_pkg, tcce_fifo, tcce_front, tcce_back
`default_nettype none

// Text console with a cursor over a ROWS x COLUMNS screen of 16-bit cells
// (character low byte, attribute high byte). Each input word gives exactly one
// result word carrying the cursor after the word, the cell read (or zero) and a
// scroll flag. A word passes the front end and a two-word command queue, so
// input is taken while the back end works. In the back end an on-screen read
// passes through the registered memory read before its result; a put that
// scrolls blanks only the new bottom row, since the screen rows are addressed
// circularly, one cell per cycle through the single memory write port; a clear
// blanks the whole memory in the same way. After reset the engine blanks the
// whole memory and holds full high meanwhile; the attribute register can be
// written during that pass.

module text_console_cursor_engine import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    // input word side
    input  logic       push,
    output logic       full,
    input  in_word_t   in_data,
    // result word side
    output logic       empty,
    input  logic       pop,
    output out_word_t  out_data,
    // text attribute register
    input  logic       cfg_write,
    input  logic [7:0] cfg_data
);

    // front to queue
    logic      q_push;
    cmd_t      q_cmd;
    logic      q_full;
    // queue to back
    cmd_t      cmd;
    logic      cmd_empty;
    logic      cmd_pop;
    // back to result queue
    logic      res_push;
    out_word_t res_word;
    logic      res_full;
    // memory blanking after reset
    logic      init_busy;

    // classify: newline, backspace, plain char, clear, draw, read, dropped draw or read
    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_data (in_data),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .busy    (init_busy),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // lets the front keep taking words while the back sweeps
    tcce_fifo #(
        .word_t (cmd_t)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_cmd),
        .full    (q_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    // cursor, screen memory and sweep sequencer
    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word),
        .init_busy (init_busy)
    );

    // result words wait here until popped
    tcce_fifo #(
        .word_t (out_word_t)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

endmodule

`default_nettype wire

>>> hdl/tcce_checker.sv
// port-level checks of the console engine, bound to the top level
// depends on tcce_pkg and text_console_cursor_engine_assert.svh
`default_nettype none

`include "text_console_cursor_engine_assert.svh"

module tcce_checker import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_word_t out_data
);

    localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
    localparam logic [6:0] COL_LIMIT = 7'(COLUMNS);

    // cursor column always on screen
    `TCCE_ASSERT_NOW(a_col_range, clk, rst_n, !empty,
        out_data.cursor_col_out < COL_LIMIT, "cursor column past last column")

    // a scroll leaves the cursor at the start of the bottom row
    `TCCE_ASSERT_NOW(a_scroll_cursor, clk, rst_n, !empty && out_data.scrolled,
        out_data.cursor_col_out == 7'd0 && out_data.cursor_row_out == ROW_LAST,
        "scroll with cursor off bottom row start")

    // only puts scroll, and puts return no cell
    `TCCE_ASSERT_NOW(a_scroll_no_read, clk, rst_n, !empty && out_data.scrolled,
        out_data.read_char == 8'd0 && out_data.read_attr == 8'd0,
        "scroll word carries read data")

    // waiting result word holds until popped
    `TCCE_ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(out_data), "waiting result word changed")

endmodule

bind text_console_cursor_engine tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
);

`default_nettype wire

>>> verif/console_screen_checker.sv
// checker for the text console cursor engine: mirrors the screen, cursor and attribute
// depends on tcce_pkg; instantiated by the testbench top beside the engine
module console_screen_checker import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  in_word_t   in_data,
    input  logic       empty,
    input  logic       pop,
    input  out_word_t  out_data,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         words_pending
);

    localparam int CELLS = ROWS * COLUMNS;

    logic [15:0] cell_mirror [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  text_attr;
    out_word_t   expected_results [$];

    // applies one input word to the mirror and returns the result word it gives
    function automatic out_word_t predict_console_result(input in_word_t w);
        out_word_t res;
        int        pr;
        int        pc;
        int        i;
        res = '0;
        pr  = $signed(w.position_row);
        pc  = $signed(w.position_col);
        case (w.action)
            ACT_PUT:
            begin
                if (w.char_code == CHR_NEWLINE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (w.char_code == CHR_BACKSPACE)
                begin
                    if (cur_col > 0)
                        cur_col--;
                    else if (cur_row > 0)
                    begin
                        cur_row--;
                        cur_col = COLUMNS - 1;
                    end
                    cell_mirror[cur_row * COLUMNS + cur_col] = {text_attr, CHR_SPACE};
                end
                else
                begin
                    cell_mirror[cur_row * COLUMNS + cur_col] = {text_attr, w.char_code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        cell_mirror[i] = cell_mirror[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        cell_mirror[i] = {text_attr, CHR_SPACE};
                    cur_row      = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    cell_mirror[i] = {text_attr, CHR_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_DRAW:
            begin
                if (pr >= 0 && pr < ROWS && pc >= 0 && pc < COLUMNS)
                    cell_mirror[pr * COLUMNS + pc] = {w.cell_attr, w.char_code};
            end
            default:
            begin
                if (pr >= 0 && pr < ROWS && pc >= 0 && pc < COLUMNS)
                    {res.read_attr, res.read_char} = cell_mirror[pr * COLUMNS + pc];
            end
        endcase
        res.cursor_row_out = 5'(cur_row);
        res.cursor_col_out = 7'(cur_col);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_word_t want;
        int        i;
        if (!rst_n)
        begin
            for (i = 0; i < CELLS; i++)
                cell_mirror[i] = {ATTR_RESET, CHR_SPACE};
            cur_row    = 0;
            cur_col    = 0;
            text_attr  = ATTR_RESET;
            mismatches = 0;
            expected_results.delete();
            words_pending <= 0;
        end
        else
        begin
            if (cfg_write)
                text_attr = cfg_data;
            if (push && !full)
                expected_results.push_back(predict_console_result(in_data));
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.cursor_row_out !== want.cursor_row_out)
                    begin
                        $error("cursor_row_out: expected %0d, got %0d",
                               want.cursor_row_out, out_data.cursor_row_out);
                        mismatches++;
                    end
                    if (out_data.cursor_col_out !== want.cursor_col_out)
                    begin
                        $error("cursor_col_out: expected %0d, got %0d",
                               want.cursor_col_out, out_data.cursor_col_out);
                        mismatches++;
                    end
                    if (out_data.read_char !== want.read_char)
                    begin
                        $error("read_char: expected %h, got %h",
                               want.read_char, out_data.read_char);
                        mismatches++;
                    end
                    if (out_data.read_attr !== want.read_attr)
                    begin
                        $error("read_attr: expected %h, got %h",
                               want.read_attr, out_data.read_attr);
                        mismatches++;
                    end
                    if (out_data.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0d, got %0d",
                               want.scrolled, out_data.scrolled);
                        mismatches++;
                    end
                end
            end
            words_pending <= expected_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
// top of the text console cursor engine testbench: clock, reset, stimulus and verdict
// depends on tcce_pkg, the engine rtl and console_screen_checker
module testbench;

    import tcce_pkg::*;

    localparam int COLUMNS         = 80;
    localparam int ROWS            = 25;
    // a clear walks every cell, so that is the longest the engine can stay busy
    localparam int SETTLE_CYCLES   = ROWS * COLUMNS + 100;
    // cycles with no word moving on either side before the run is called hung
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 212;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    in_word_t   in_data   = '0;
    logic       empty;
    logic       pop       = 1'b0;
    out_word_t  out_data;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data  = 8'h00;

    // idling knobs, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // share of put words that are newlines; low values let long lines wrap
    int newline_pct    = 25;

    int mismatches;
    int words_pending;
    int quiet_cycles = 0;

    text_console_cursor_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    console_screen_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_data       (in_data),
        .empty         (empty),
        .pop           (pop),
        .out_data      (out_data),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: one fresh pop decision per cycle, stalls at the phase's rate
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: counts cycles in which no word is accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_console_cursor_engine: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic in_word_t console_word(input logic [1:0] action, input logic [7:0] ch,
                                              input int row, input int col,
                                              input logic [7:0] attr);
        in_word_t w;
        w.action       = action;
        w.char_code    = ch;
        w.position_row = 8'(row);
        w.position_col = 8'(col);
        w.cell_attr    = attr;
        return w;
    endfunction

    // mostly puts so the cursor walks down and scrolls, plus draws, reads and rare clears
    function automatic in_word_t random_console_word();
        in_word_t w;
        int       pick;
        w.char_code    = 8'($urandom);
        w.cell_attr    = 8'($urandom);
        // mostly on screen; the rest spans the full signed range, off-screen included
        w.position_row = ($urandom_range(99) < 85) ? 8'($urandom_range(ROWS - 1)) : 8'($urandom);
        w.position_col = ($urandom_range(99) < 85) ? 8'($urandom_range(COLUMNS - 1))
                                                   : 8'($urandom);
        pick = $urandom_range(999);
        if (pick < 3)
            w.action = ACT_CLEAR;
        else if (pick < 600)
        begin
            w.action = ACT_PUT;
            pick     = $urandom_range(99);
            if (pick < newline_pct)
                w.char_code = CHR_NEWLINE;
            else if (pick < newline_pct + 8)
                w.char_code = CHR_BACKSPACE;
        end
        else if (pick < 760)
            w.action = ACT_DRAW;
        else
            w.action = ACT_READ;
        return w;
    endfunction

    // push stays high from word to word unless the sender decides to idle first
    task automatic send_console_word(input in_word_t w);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop sending, wait for every expected result word, then let a clear or
    // scroll blanking run out before anything else touches the engine
    task automatic settle_console();
        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_text_attribute(input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        in_word_t   directed [$];
        logic [7:0] attr_plan [RANDOM_PHASES];
        int         p;
        int         n;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // the engine blanks its store after reset and holds full meanwhile
        while (full)
            @(posedge clk);

        // directed part, run with the reset attribute and no idling
        // backspace at home blanks the home cell and keeps the cursor
        directed.push_back(console_word(ACT_PUT, CHR_BACKSPACE, 0, 0, 8'h00));
        directed.push_back(console_word(ACT_PUT, 8'h41, 0, 0, 8'h00));
        // top-bit character must stay an unsigned byte
        directed.push_back(console_word(ACT_PUT, 8'hFF, -1, -1, 8'hFF));
        directed.push_back(console_word(ACT_PUT, 8'h00, 0, 0, 8'h00));
        directed.push_back(console_word(ACT_PUT, CHR_NEWLINE, 0, 0, 8'h00));
        // backspace at column 0 steps back to the end of the row above
        directed.push_back(console_word(ACT_PUT, CHR_BACKSPACE, 0, 0, 8'h00));
        // draws at two opposite screen corners with extreme characters and attributes
        directed.push_back(console_word(ACT_DRAW, 8'h00, 0, 0, 8'hFF));
        directed.push_back(console_word(ACT_DRAW, 8'hFF, ROWS - 1, COLUMNS - 1, 8'h00));
        // off-screen draws just past each edge and at the signed extremes
        directed.push_back(console_word(ACT_DRAW, 8'h55, -1, 0, 8'hAA));
        directed.push_back(console_word(ACT_DRAW, 8'h55, 0, -1, 8'hAA));
        directed.push_back(console_word(ACT_DRAW, 8'h55, ROWS, 0, 8'hAA));
        directed.push_back(console_word(ACT_DRAW, 8'h55, 0, COLUMNS, 8'hAA));
        directed.push_back(console_word(ACT_DRAW, 8'h55, 127, 127, 8'hAA));
        directed.push_back(console_word(ACT_DRAW, 8'h55, -128, -128, 8'hAA));
        // reads back on screen, then off-screen reads that must give zero
        directed.push_back(console_word(ACT_READ, 8'h00, 0, 0, 8'h00));
        directed.push_back(console_word(ACT_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
        directed.push_back(console_word(ACT_READ, 8'h00, 0, 1, 8'h00));
        directed.push_back(console_word(ACT_READ, 8'h00, 0, COLUMNS - 1, 8'h00));
        directed.push_back(console_word(ACT_READ, 8'hFF, -1, 5, 8'hFF));
        directed.push_back(console_word(ACT_READ, 8'hFF, 5, COLUMNS, 8'hFF));
        directed.push_back(console_word(ACT_READ, 8'hFF, -128, 127, 8'hFF));
        directed.push_back(console_word(ACT_READ, 8'hFF, ROWS, 0, 8'hFF));
        // clear, then confirm a formerly written cell is blank again
        directed.push_back(console_word(ACT_CLEAR, 8'h00, 0, 0, 8'h00));
        directed.push_back(console_word(ACT_READ, 8'h00, 0, 1, 8'h00));
        foreach (directed[i])
            send_console_word(directed[i]);
        // the sender pauses here until every expected word has come back
        settle_console();

        // attribute settings per random phase, both extremes among them
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = 8'($urandom);
        attr_plan[3] = 8'h80;
        attr_plan[4] = 8'h7F;
        attr_plan[5] = 8'($urandom);
        attr_plan[6] = ATTR_RESET;
        attr_plan[7] = 8'($urandom);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            // engine is idle here, so the attribute can change
            write_text_attribute(attr_plan[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            // alternate newline-heavy phases (many scrolls) with long-line phases (wraps)
            newline_pct = (p % 2 == 0) ? 25 : 3;
            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_console_word(random_console_word());
            settle_console();
        end

        if (mismatches == 0 && words_pending == 0)
            $display("text_console_cursor_engine: match");
        else
            $display("text_console_cursor_engine: mismatch");
        $finish;
    end

endmodule

>>> text_console_cursor_engine.f
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_fifo.sv
hdl/tcce_front.sv
hdl/tcce_back.sv
hdl/text_console_cursor_engine.sv
hdl/tcce_checker.sv
verif/console_screen_checker.sv
verif/testbench.sv
